// File: sv/psq_pkg.sv
// Package for the positional sequence store: beat structs, command and
// status codes, sequencer states and sizing constants.
// No dependencies.
package psq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 5;
	localparam int POS_W    = 5;
	localparam int CMD_W    = 3;
	localparam int WORD_W   = 32;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT_AT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ_AT    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic [POS_W-1:0]         position;
		logic signed [WORD_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value_out;
		logic [1:0]               status;
		logic [CNT_W-1:0]         element_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_WR,
		S_PUT,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_INS,
		OP_DEL,
		OP_READ
	} op_t;

endpackage

// File: sv/psq_ram.sv
// Generic one-write, one-read memory with registered read data.
// No dependencies.
module psq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: sv/positional_sequence_store_unit.sv
// Positional sequence store: top level with command sequencer and cell memory.
// Depends on psq_pkg and psq_ram.
//
// A command is taken when start is high and busy is low; busy then stays high
// until its result has been shown. The result appears on result for exactly one
// cycle with done high and must be taken then: the block does not wait. A
// command that reads and writes no cell goes from accept straight to done; a
// read passes through a read and a write state; an insert or remove shifts
// the later elements one at a time, since the cells sit in a single-port-write
// memory and each moves by one read and one write through the shared pointer
// unit. The next command can be accepted in the cycle after done.
module positional_sequence_store_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  psq_pkg::req_t request,
	output logic          done,
	output psq_pkg::rsp_t result
);

	psq_pkg::state_t state_q, state_d;
	psq_pkg::op_t    op_q, op_d;

	logic [psq_pkg::CNT_W-1:0]  count_q, cnt_d;
	logic [psq_pkg::IDX_W-1:0]  p_q, p_d;
	logic [psq_pkg::IDX_W-1:0]  stop_q, stop_d;
	logic [psq_pkg::IDX_W-1:0]  put_q, put_d;
	logic [psq_pkg::WORD_W-1:0] word_q;
	logic [psq_pkg::WORD_W-1:0] value_q;
	logic [1:0]                 status_q, st_d;
	psq_pkg::state_t            go_d;

	logic                       accept;
	logic [psq_pkg::CNT_W-1:0]  n, n1, pm1, idx5;
	logic                       full;

	logic                       ram_we;
	logic [psq_pkg::IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [psq_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
	logic                       last;

	assign accept = start && !busy;
	assign n      = count_q;
	assign n1     = count_q + 5'd1;
	assign pm1    = request.position - 5'd1;
	assign full   = count_q >= psq_pkg::CNT_W'(psq_pkg::CAPACITY);
	assign last   = (p_q == stop_q);

	// command decode and checks
	always_comb begin
		st_d   = psq_pkg::ST_OK;
		cnt_d  = n;
		go_d   = psq_pkg::S_DONE;
		op_d   = psq_pkg::OP_INS;
		p_d    = '0;
		stop_d = '0;
		put_d  = '0;
		idx5   = '0;
		case (request.command)
			psq_pkg::CMD_PUSH_FRONT, psq_pkg::CMD_PUSH_BACK, psq_pkg::CMD_INSERT_AT: begin
				if (request.command == psq_pkg::CMD_PUSH_FRONT) begin
					idx5 = '0;
				end else if (request.command == psq_pkg::CMD_PUSH_BACK) begin
					idx5 = n;
				end else begin
					idx5 = pm1;
				end
				if (request.command == psq_pkg::CMD_INSERT_AT &&
				    (request.position == '0 || request.position > n1)) begin
					st_d = psq_pkg::ST_RANGE;
				end else if (full) begin
					st_d = psq_pkg::ST_FULL;
				end else begin
					cnt_d  = n1;
					op_d   = psq_pkg::OP_INS;
					put_d  = idx5[psq_pkg::IDX_W-1:0];
					stop_d = idx5[psq_pkg::IDX_W-1:0];
					p_d    = pm1[psq_pkg::IDX_W-1:0];
					p_d    = psq_pkg::IDX_W'(n - 5'd1);
					go_d   = (idx5 < n) ? psq_pkg::S_RD : psq_pkg::S_PUT;
				end
			end
			psq_pkg::CMD_POP_FRONT, psq_pkg::CMD_REMOVE_AT: begin
				idx5 = (request.command == psq_pkg::CMD_POP_FRONT) ? '0 : pm1;
				if (n == '0) begin
					st_d = psq_pkg::ST_EMPTY;
				end else if (request.command == psq_pkg::CMD_REMOVE_AT &&
				             (request.position == '0 || request.position > n)) begin
					st_d = psq_pkg::ST_RANGE;
				end else begin
					cnt_d  = n - 5'd1;
					op_d   = psq_pkg::OP_DEL;
					p_d    = idx5[psq_pkg::IDX_W-1:0];
					stop_d = psq_pkg::IDX_W'(n - 5'd2);
					go_d   = (idx5 + 5'd1 < n) ? psq_pkg::S_RD : psq_pkg::S_DONE;
				end
			end
			psq_pkg::CMD_READ_AT: begin
				if (request.position == '0 || request.position == n1) begin
					st_d = psq_pkg::ST_RANGE;
				end else if (n == '0) begin
					st_d = psq_pkg::ST_EMPTY;
				end else if (request.position > n) begin
					st_d = psq_pkg::ST_RANGE;
				end else begin
					op_d = psq_pkg::OP_READ;
					p_d  = pm1[psq_pkg::IDX_W-1:0];
					go_d = psq_pkg::S_RD;
				end
			end
			psq_pkg::CMD_CLEAR: begin
				cnt_d = '0;
			end
			default: begin
				st_d = psq_pkg::ST_OK;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			psq_pkg::S_IDLE: begin
				if (start) begin
					state_d = go_d;
				end
			end
			psq_pkg::S_RD: begin
				state_d = psq_pkg::S_WR;
			end
			psq_pkg::S_WR: begin
				if (op_q == psq_pkg::OP_READ) begin
					state_d = psq_pkg::S_DONE;
				end else if (!last) begin
					state_d = psq_pkg::S_RD;
				end else if (op_q == psq_pkg::OP_INS) begin
					state_d = psq_pkg::S_PUT;
				end else begin
					state_d = psq_pkg::S_DONE;
				end
			end
			psq_pkg::S_PUT: begin
				state_d = psq_pkg::S_DONE;
			end
			psq_pkg::S_DONE: begin
				state_d = psq_pkg::S_IDLE;
			end
			default: begin
				state_d = psq_pkg::S_IDLE;
			end
		endcase
	end

	// outputs and memory controls
	always_comb begin
		busy      = 1'b1;
		done      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = p_q;
		ram_wdata = ram_rdata;
		ram_raddr = (op_q == psq_pkg::OP_DEL) ? p_q + 1'b1 : p_q;
		case (state_q)
			psq_pkg::S_IDLE: begin
				busy = 1'b0;
			end
			psq_pkg::S_RD: begin
				ram_we = 1'b0;
			end
			psq_pkg::S_WR: begin
				ram_we    = (op_q != psq_pkg::OP_READ);
				ram_waddr = (op_q == psq_pkg::OP_INS) ? p_q + 1'b1 : p_q;
			end
			psq_pkg::S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = put_q;
				ram_wdata = word_q;
			end
			psq_pkg::S_DONE: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psq_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_d;
			p_q      <= p_d;
			stop_q   <= stop_d;
			put_q    <= put_d;
			word_q   <= request.value_in;
			status_q <= st_d;
			value_q  <= '0;
		end else if (state_q == psq_pkg::S_WR) begin
			if (op_q == psq_pkg::OP_READ) begin
				value_q <= ram_rdata;
			end else if (op_q == psq_pkg::OP_INS) begin
				p_q <= p_q - 1'b1;
			end else begin
				p_q <= p_q + 1'b1;
			end
		end
	end

	psq_ram #(
		.DEPTH (psq_pkg::CAPACITY),
		.WIDTH (psq_pkg::WORD_W)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign result.value_out     = value_q;
	assign result.status        = status_q;
	assign result.element_count = count_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after accepted beat");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.element_count <= psq_pkg::CNT_W'(psq_pkg::CAPACITY))
		else $error("element count above capacity");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != psq_pkg::ST_OK |-> result.value_out == '0)
		else $error("value on failed command");

endmodule

// File: tb/tb_positional_sequence_store_unit.sv
// Testbench for positional_sequence_store_unit: directed and random commands on the
// start/busy handshake, each done beat checked against a behavioral model of the store.
// Depends on psq_pkg and the unit RTL.
module tb_positional_sequence_store_unit;

	localparam logic [psq_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	psq_pkg::req_t request = '0;
	logic done;
	psq_pkg::rsp_t result;

	psq_pkg::req_t cmd_queue[$];
	psq_pkg::rsp_t rsp_due[$];
	logic signed [psq_pkg::WORD_W-1:0] slot[psq_pkg::CAPACITY];
	int held = 0;
	int taken = 0;
	int errors = 0;

	positional_sequence_store_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void put_word(int idx, logic signed [psq_pkg::WORD_W-1:0] word);
		for (int i = held; i > idx; i--)
			slot[i] = slot[i-1];
		slot[idx] = word;
		held++;
	endfunction

	function automatic void drop_word(int idx);
		for (int i = idx; i < held - 1; i++)
			slot[i] = slot[i+1];
		held--;
	endfunction

	function automatic psq_pkg::rsp_t store_step(psq_pkg::req_t rq);
		psq_pkg::rsp_t r;
		int p;
		r = '0;
		p = rq.position;
		case (rq.command)
			psq_pkg::CMD_PUSH_FRONT: begin
				if (held >= psq_pkg::CAPACITY) r.status = psq_pkg::ST_FULL;
				else put_word(0, rq.value_in);
			end
			psq_pkg::CMD_PUSH_BACK: begin
				if (held >= psq_pkg::CAPACITY) r.status = psq_pkg::ST_FULL;
				else put_word(held, rq.value_in);
			end
			psq_pkg::CMD_INSERT_AT: begin
				if (p == 0 || p > held + 1) r.status = psq_pkg::ST_RANGE;
				else if (held >= psq_pkg::CAPACITY) r.status = psq_pkg::ST_FULL;
				else put_word(p - 1, rq.value_in);
			end
			psq_pkg::CMD_POP_FRONT: begin
				if (held == 0) r.status = psq_pkg::ST_EMPTY;
				else drop_word(0);
			end
			psq_pkg::CMD_REMOVE_AT: begin
				if (held == 0) r.status = psq_pkg::ST_EMPTY;
				else if (p == 0 || p > held) r.status = psq_pkg::ST_RANGE;
				else drop_word(p - 1);
			end
			psq_pkg::CMD_READ_AT: begin
				if (p == 0 || p == held + 1) r.status = psq_pkg::ST_RANGE;
				else if (held == 0) r.status = psq_pkg::ST_EMPTY;
				else if (p > held) r.status = psq_pkg::ST_RANGE;
				else r.value_out = slot[p-1];
			end
			psq_pkg::CMD_CLEAR: held = 0;
			default: ;
		endcase
		r.element_count = psq_pkg::CNT_W'(held);
		return r;
	endfunction

	// queued items are run through the model once to steer positions by fill level
	function automatic void add_item(logic [psq_pkg::CMD_W-1:0] cmd, int pos,
			logic [psq_pkg::WORD_W-1:0] word);
		psq_pkg::req_t rq;
		rq.command = cmd;
		rq.position = psq_pkg::POS_W'(pos);
		rq.value_in = word;
		cmd_queue.insert(cmd_queue.size(), rq);
		void'(store_step(rq));
	endfunction

	function automatic logic [psq_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(19))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				rsp_due.insert(rsp_due.size(), store_step(request));
				taken++;
			end
			if (!(start && busy)) begin
				if (cmd_queue.size() > 0 &&
						((taken >= 700 && taken < 1000) || $urandom_range(99) >= 17)) begin
					request <= cmd_queue.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (rsp_due.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, result);
				errors++;
			end else begin
				psq_pkg::rsp_t want;
				want = rsp_due.pop_front();
				if (result.value_out !== want.value_out) begin
					$display("%0t: value_out expected %h got %h", $time,
						want.value_out, result.value_out);
					errors++;
				end
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						want.status, result.status);
					errors++;
				end
				if (result.element_count !== want.element_count) begin
					$display("%0t: element_count expected %0d got %0d", $time,
						want.element_count, result.element_count);
					errors++;
				end
			end
		end
	end

	initial begin
		int mode;
		int left;
		int r;
		int pos;
		int p_add;
		int p_del;
		logic [psq_pkg::CMD_W-1:0] cmd;

		// directed corner cases on empty and filled store, bad positions and commands
		add_item(psq_pkg::CMD_READ_AT, 0, 0);
		add_item(psq_pkg::CMD_READ_AT, 1, 0);
		add_item(psq_pkg::CMD_READ_AT, 2, 0);
		add_item(psq_pkg::CMD_POP_FRONT, 0, 0);
		add_item(psq_pkg::CMD_REMOVE_AT, 1, 0);
		add_item(psq_pkg::CMD_INSERT_AT, 0, 32'h1111_1111);
		add_item(psq_pkg::CMD_INSERT_AT, 2, 32'h2222_2222);
		add_item(psq_pkg::CMD_INSERT_AT, 1, 32'h8000_0000);
		add_item(psq_pkg::CMD_PUSH_FRONT, 17, 32'h7fff_ffff);
		add_item(psq_pkg::CMD_PUSH_BACK, 31, 32'hffff_ffff);
		add_item(psq_pkg::CMD_PUSH_BACK, 0, 32'h0000_0000);
		add_item(psq_pkg::CMD_INSERT_AT, 5, 32'h5a5a_5a5a);
		add_item(psq_pkg::CMD_INSERT_AT, 3, 32'h1234_5678);
		add_item(psq_pkg::CMD_READ_AT, 1, 0);
		add_item(psq_pkg::CMD_READ_AT, 6, 0);
		add_item(psq_pkg::CMD_READ_AT, 7, 0);
		add_item(psq_pkg::CMD_READ_AT, 17, 0);
		add_item(psq_pkg::CMD_REMOVE_AT, 0, 0);
		add_item(psq_pkg::CMD_REMOVE_AT, 7, 0);
		add_item(psq_pkg::CMD_REMOVE_AT, 3, 0);
		add_item(psq_pkg::CMD_POP_FRONT, 0, 0);
		add_item(CMD_UNUSED, 17, 32'hdead_beef);
		add_item(psq_pkg::CMD_CLEAR, 9, 0);
		add_item(psq_pkg::CMD_READ_AT, 16, 0);

		mode = 0;
		left = 0;
		for (int n = 0; n < 1800; n++) begin
			if (left == 0) begin
				mode = $urandom_range(2);
				left = $urandom_range(120, 40);
			end
			left--;
			case (mode)
				0: begin p_add = 70; p_del = 15; end
				1: begin p_add = 20; p_del = 65; end
				default: begin p_add = 40; p_del = 40; end
			endcase
			r = $urandom_range(99);
			if (r == 0)
				cmd = psq_pkg::CMD_CLEAR;
			else if (r < p_add)
				cmd = psq_pkg::CMD_W'($urandom_range(2));
			else if (r < p_add + p_del)
				cmd = $urandom_range(1) ? psq_pkg::CMD_POP_FRONT : psq_pkg::CMD_REMOVE_AT;
			else if (r < 97)
				cmd = psq_pkg::CMD_READ_AT;
			else
				cmd = psq_pkg::CMD_W'($urandom_range(6));
			if ($urandom_range(99) < 85) begin
				if (cmd == psq_pkg::CMD_INSERT_AT)
					pos = $urandom_range(held + 1, 1);
				else
					pos = (held == 0) ? 1 : $urandom_range(held, 1);
			end else begin
				pos = $urandom_range(17);
			end
			add_item(cmd, pos, pick_word());
		end
		held = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (cmd_queue.size() != 0 || start || rsp_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("positional_sequence_store_unit verification clean");
		else
			$display("positional_sequence_store_unit verification failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("positional_sequence_store_unit verification failed");
		$finish;
	end

endmodule
